@@ src/oile_pkg.sv @@
// Shared types and constants of the ordered integer list engine.
package oile_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [REQ_W-1:0]         req_code_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DELETE     = 3'd4,
    REQ_SEARCH     = 3'd5
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic take_left;
    logic take_right;
    logic take_right_hit;
    logic load;
  } cell_ctrl_t;

endpackage

@@ src/oile_req_if.sv @@
// Request channel interface of the ordered integer list engine.
interface oile_req_if;
  logic                      valid;
  logic                      ready;
  oile_pkg::req_code_t       req_type;
  oile_pkg::data_t           value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

@@ src/oile_rsp_if.sv @@
// Result channel interface of the ordered integer list engine.
interface oile_rsp_if;
  logic             valid;
  logic             ready;
  logic             ok;
  logic             hit;
  logic             overflow;
  oile_pkg::len_t   length;

  modport source (output valid, output ok, output hit, output overflow, output length,
                  input ready);
  modport sink   (input valid, input ok, input hit, input overflow, input length,
                  output ready);
endinterface

@@ src/oile_cell.sv @@
// One storage cell of the list chain: holds an entry, compares it and shifts it.
module oile_cell (
  input  logic                 clk,
  input  oile_pkg::cell_ctrl_t ctrl,
  input  logic                 occ,
  input  logic                 load_sel,
  input  oile_pkg::data_t      cmp_value,
  input  oile_pkg::data_t      upd_value,
  input  oile_pkg::data_t      left_data,
  input  oile_pkg::data_t      right_data,
  input  logic                 hit_in,
  output oile_pkg::data_t      data_out,
  output logic                 hit_out
);
  import oile_pkg::*;

  data_t data_r, data_nxt;
  logic  match_r, match_nxt;
  logic  hit_here;

  assign hit_here = hit_in | match_r;
  assign hit_out  = hit_here;
  assign data_out = data_r;

  always_comb begin
    match_nxt = match_r;
    if (ctrl.capture) begin
      match_nxt = occ && (data_r == cmp_value);
    end
  end

  always_comb begin
    priority if (ctrl.take_left) begin
      data_nxt = left_data;
    end else if (ctrl.take_right || (ctrl.take_right_hit && hit_here)) begin
      data_nxt = right_data;
    end else if (ctrl.load && load_sel) begin
      data_nxt = upd_value;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

endmodule

@@ src/ordered_int_list_engine_top.sv @@
// Top level of the ordered integer list engine: control, length counter and cell chain.
// In the cycle a request is accepted every cell compares its entry with the request
// value and registers the match; in the execute state that follows, the first-match flag
// ripples down the cell chain, the cells shift or load, and the result is registered.
// No new request is taken until the engine is back in idle; a result left waiting on the
// output holds the execute state until the output register is free.
// Storage needs no clearing after reset: only entries below the length are ever read.
module ordered_int_list_engine_top (
  input  logic     clk,
  input  logic     rst_n,
  oile_req_if.sink   in_req,
  oile_rsp_if.source out_rsp
);
  import oile_pkg::*;

  state_t     state_r, state_nxt;
  len_t       count_r, count_nxt;
  req_code_t  req_r;
  data_t      val_r;
  logic       out_valid_r, out_valid_nxt;
  logic       ok_r, ok_nxt;
  logic       hit_r, hit_nxt;
  logic       ovf_r, ovf_nxt;
  len_t       len_r;

  logic       accept;
  logic       go;
  logic       full;
  logic       empty;
  logic       found;
  cell_ctrl_t ctrl;

  data_t                cell_data [CAPACITY];
  logic [CAPACITY:0]    hit_chain;
  logic [CAPACITY-1:0]  occ;
  logic [CAPACITY-1:0]  load_sel;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign go           = (state_r == ST_EXEC) && (!out_valid_r || out_rsp.ready);
  assign full         = (count_r == len_t'(CAPACITY));
  assign empty        = (count_r == '0);
  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[CAPACITY];

  assign ctrl.capture        = accept;
  assign ctrl.take_left      = go && (req_r == REQ_PUSH_FRONT) && !full;
  assign ctrl.take_right     = go && (req_r == REQ_POP_FRONT) && !empty;
  assign ctrl.take_right_hit = go && (req_r == REQ_DELETE);
  assign ctrl.load           = go && (req_r == REQ_PUSH_BACK) && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t left_d, right_d;

    assign occ[i]      = (len_t'(i) < count_r);
    assign load_sel[i] = (len_t'(i) == count_r);

    if (i == 0) begin : g_first
      assign left_d = val_r;
    end else begin : g_inner
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = val_r;
    end else begin : g_body
      assign right_d = cell_data[i+1];
    end

    oile_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ[i]),
      .load_sel   (load_sel[i]),
      .cmp_value  (in_req.value),
      .upd_value  (val_r),
      .left_data  (left_d),
      .right_data (right_d),
      .hit_in     (hit_chain[i]),
      .data_out   (cell_data[i]),
      .hit_out    (hit_chain[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    ok_nxt        = 1'b0;
    hit_nxt       = 1'b0;
    ovf_nxt       = 1'b0;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          unique case (req_r)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                ok_nxt    = 1'b1;
                count_nxt = count_r + len_t'(1);
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (!empty) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r - len_t'(1);
              end
            end
            REQ_DELETE: begin
              if (!empty) begin
                ok_nxt = 1'b1;
                if (found) begin
                  hit_nxt   = 1'b1;
                  count_nxt = count_r - len_t'(1);
                end
              end
            end
            REQ_SEARCH: begin
              ok_nxt  = found;
              hit_nxt = found;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req.req_type;
      val_r <= in_req.value;
    end
    if (go) begin
      ok_r  <= ok_nxt;
      hit_r <= hit_nxt;
      ovf_r <= ovf_nxt;
      len_r <= count_nxt;
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.ok       = ok_r;
  assign out_rsp.hit      = hit_r;
  assign out_rsp.overflow = ovf_r;
  assign out_rsp.length   = len_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= len_t'(CAPACITY))
    else $error("length above capacity");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result raised without an executing request");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC) && !in_req.ready)
    else $error("request taken while another is executing");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ovf_r && ok_r) && (!hit_r || ok_r))
    else $error("inconsistent result flags");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the ordered integer list engine: directed and random deque traffic.
module testbench;
  import oile_pkg::*;

  localparam req_code_t REQ_SPARE_LO  = 3'd6;
  localparam req_code_t REQ_SPARE_HI  = 3'd7;
  localparam data_t     TOP_VAL       = 32'sh7FFF_FFFF;
  localparam data_t     BOTTOM_VAL    = 32'sh8000_0000;
  localparam int        CYCLE_LIMIT   = 300000;
  localparam int        SETTLE_CYCLES = 20;
  localparam int        PHASE_ITEMS   = 385;
  localparam int        BURST_LEN     = 24;

  typedef struct packed {
    logic ok;
    logic hit;
    logic overflow;
    len_t length;
  } list_result_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} traffic_mix_t;

  class list_scoreboard;
    data_t        shadow[$];
    list_result_t awaited[$];
    int           mismatches;

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(req_code_t code, data_t val);
      list_result_t res;
      int           found;
      res   = '0;
      found = -1;
      foreach (shadow[i])
        if (found < 0 && shadow[i] == val) found = i;
      case (code)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (shadow.size() >= CAPACITY) begin
            res.overflow = 1'b1;
          end else begin
            if (code == REQ_PUSH_FRONT) shadow.push_front(val);
            else shadow.push_back(val);
            res.ok = 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (shadow.size() > 0) begin
            void'(shadow.pop_front());
            res.ok = 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (shadow.size() > 0) begin
            void'(shadow.pop_back());
            res.ok = 1'b1;
          end
        end
        REQ_DELETE: begin
          if (shadow.size() > 0) begin
            res.ok = 1'b1;
            if (found >= 0) begin
              shadow.delete(found);
              res.hit = 1'b1;
            end
          end
        end
        REQ_SEARCH: begin
          if (found >= 0) begin
            res.ok  = 1'b1;
            res.hit = 1'b1;
          end
        end
        default: ;
      endcase
      res.length = len_t'(shadow.size());
      awaited.push_back(res);
    endfunction

    task check_result(logic ok, logic hit, logic overflow, len_t length);
      list_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result ok=%0b hit=%0b ovf=%0b len=%0d with none outstanding",
                                  ok, hit, overflow, length));
      end else begin
        want = awaited.pop_front();
        if (ok !== want.ok)
          report_mismatch($sformatf("ok got %0b want %0b", ok, want.ok));
        if (hit !== want.hit)
          report_mismatch($sformatf("hit got %0b want %0b", hit, want.hit));
        if (overflow !== want.overflow)
          report_mismatch($sformatf("overflow got %0b want %0b", overflow, want.overflow));
        if (length !== want.length)
          report_mismatch($sformatf("length got %0d want %0d", length, want.length));
      end
    endtask
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  int             cycles = 0;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             idle_tab[4] = '{0, 70, 0, 18};
  int             stall_tab[4] = '{0, 0, 70, 18};
  traffic_mix_t   mix;
  list_scoreboard sb = new();

  oile_req_if req_ch ();
  oile_rsp_if rsp_ch ();

  ordered_int_list_engine_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_rsp (rsp_ch.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk)
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      sb.check_result(rsp_ch.ok, rsp_ch.hit, rsp_ch.overflow, rsp_ch.length);
    if (rst_n && req_ch.valid && req_ch.ready)
      sb.note_request(req_ch.req_type, req_ch.value);
  end

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return data_t'(int'($urandom_range(6)) - 3);
      5:             return TOP_VAL;
      6:             return BOTTOM_VAL;
      default:       return data_t'($urandom);
    endcase
  endfunction

  function automatic req_code_t pick_code(traffic_mix_t flavour);
    int roll;
    int push_pct;
    int search_pct;
    roll = $urandom_range(99);
    if (roll < 3) return $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    case (flavour)
      MIX_FILL:  begin push_pct = 70; search_pct = 15; end
      MIX_DRAIN: begin push_pct = 15; search_pct = 15; end
      default:   begin push_pct = 35; search_pct = 25; end
    endcase
    if (roll < push_pct) return $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    if (roll < push_pct + search_pct) return REQ_SEARCH;
    case ($urandom_range(2))
      0:       return REQ_POP_FRONT;
      1:       return REQ_POP_BACK;
      default: return REQ_DELETE;
    endcase
  endfunction

  task automatic send_request(req_code_t code, data_t val);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= code;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_PUSH_FRONT;
    req_ch.value    <= '0;
    rst_n           <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store
    send_request(REQ_SPARE_LO, 32'sd1);
    send_request(REQ_SPARE_HI, -32'sd1);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_DELETE, 32'sd0);
    send_request(REQ_SEARCH, 32'sd0);
    // extremes and a duplicate, then first-match delete
    send_request(REQ_PUSH_FRONT, TOP_VAL);
    send_request(REQ_PUSH_BACK, BOTTOM_VAL);
    send_request(REQ_PUSH_FRONT, 32'sd0);
    send_request(REQ_PUSH_BACK, -32'sd1);
    send_request(REQ_PUSH_BACK, 32'sd0);
    send_request(REQ_SEARCH, BOTTOM_VAL);
    send_request(REQ_SEARCH, 32'sd5);
    send_request(REQ_DELETE, 32'sd5);
    send_request(REQ_DELETE, 32'sd0);
    send_request(REQ_SEARCH, 32'sd0);
    send_request(REQ_SPARE_LO, TOP_VAL);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_BACK, 32'sd0);
    wait_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % BURST_LEN == 0) mix = traffic_mix_t'($urandom_range(2));
        send_request(pick_code(mix), pick_value());
      end
      wait_until_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/oile_pkg.sv
src/oile_req_if.sv
src/oile_rsp_if.sv
src/oile_cell.sv
src/ordered_int_list_engine_top.sv
bench/testbench.sv
